[sv/websocket_frame_receiver_defines.svh]
// Assertion macros for the WebSocket frame receiver.
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// cons must hold in the same cycle as ante
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/wsfr_pkg.sv]
// Shared types and constants of the WebSocket frame receiver.
`timescale 1ns / 1ps

package wsfr_pkg;

    localparam logic [31:0] MAX_SIZE_RESET = 32'd33554432;
    localparam int          QUEUE_DEPTH    = 4;

    // event kinds
    localparam logic [2:0] EV_BYTE      = 3'd0;
    localparam logic [2:0] EV_EMPTY_END = 3'd1;
    localparam logic [2:0] EV_PONG      = 3'd2;
    localparam logic [2:0] EV_CLOSED    = 3'd3;
    localparam logic [2:0] EV_TOO_LARGE = 3'd4;

    // opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] payload_byte;
        logic [3:0] message_type;
        logic       message_last;
    } t_event;

    typedef struct packed {
        logic evt_valid;
        logic dead;
    } t_front_status;

endpackage

[sv/wsfr_parser.sv]
// Front end: header/length/key parsing, unmasking and event generation.
`timescale 1ns / 1ps

module wsfr_parser import wsfr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    input  logic [31:0]   i_max_size,
    output t_event        o_evt,
    output t_front_status o_status
);

    localparam logic [2:0] PH_HDR1    = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DEAD    = 3'd5;

    logic [2:0]  r_phase,  n_phase;
    logic        r_final,  n_final;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [3:0]  r_lbl,    n_lbl;
    logic [63:0] r_fr,     n_fr;
    logic [31:0] r_key,    n_key;
    logic [1:0]  r_kidx,   n_kidx;
    logic [31:0] r_ml,     n_ml;
    logic [3:0]  r_mop,    n_mop;

    logic        evt_valid;
    t_event      evt;
    logic [6:0]  len_code;
    logic        is_ext;
    logic [63:0] ext_fr;
    logic [63:0] fr_done;
    logic [63:0] bp_fr;
    logic [63:0] fr_dec;
    logic [3:0]  lbl_dec;
    logic        is_data;
    logic        masked_now;
    logic [32:0] sum;
    logic        too_big;
    logic        do_check;
    logic        do_after;
    logic        do_begin;
    logic [7:0]  key_byte;
    logic        last;

    always_comb begin
        len_code   = i_rx_byte[6:0];
        is_ext     = (len_code == LEN16_CODE) || (len_code == LEN64_CODE);
        ext_fr     = {r_fr[55:0], i_rx_byte};
        fr_done    = (r_phase == PH_HDR2) ? {57'd0, len_code} : ext_fr;
        bp_fr      = (r_phase == PH_KEY) ? r_fr : fr_done;
        fr_dec     = r_fr - 64'd1;
        lbl_dec    = r_lbl - 4'd1;
        is_data    = (r_opcode <= OP_BINARY);
        masked_now = (r_phase == PH_HDR2) ? i_rx_byte[7] : r_masked;
        // limit fits 32 bits, so any high length bit fails the check
        sum        = {1'b0, r_ml} + {1'b0, fr_done[31:0]};
        too_big    = (fr_done[63:32] != 32'd0) || (sum >= {1'b0, i_max_size});
        last       = (fr_dec == 64'd0);
        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_final   = r_final;
        n_opcode  = r_opcode;
        n_masked  = r_masked;
        n_lbl     = r_lbl;
        n_fr      = r_fr;
        n_key     = r_key;
        n_kidx    = r_kidx;
        n_ml      = r_ml;
        n_mop     = r_mop;
        evt_valid = 1'b0;
        evt       = '0;
        do_check  = 1'b0;
        do_after  = 1'b0;
        do_begin  = 1'b0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_final  = i_rx_byte[7];
                    n_opcode = i_rx_byte[3:0];
                    if ((i_rx_byte[3:0] == OP_TEXT || i_rx_byte[3:0] == OP_BINARY)
                        && r_mop == OP_CONT) begin
                        n_mop = i_rx_byte[3:0];
                    end
                    n_kidx  = 2'd0;
                    n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    n_masked = i_rx_byte[7];
                    n_fr     = 64'd0;
                    if (r_opcode == OP_CLOSE) begin
                        n_phase          = PH_DEAD;
                        evt_valid        = 1'b1;
                        evt.event_kind   = EV_CLOSED;
                    end else begin
                        if (is_ext) begin
                            n_lbl   = (len_code == LEN16_CODE) ? 4'd2 : 4'd8;
                            n_phase = PH_EXTLEN;
                        end else begin
                            n_fr = fr_done;
                        end
                        if (r_opcode == OP_PING) begin
                            // rest of the ping frame is skipped
                            do_after       = !is_ext;
                            evt_valid      = 1'b1;
                            evt.event_kind = EV_PONG;
                        end else begin
                            do_check = !is_ext;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_fr     = ext_fr;
                    n_lbl    = lbl_dec;
                    do_check = (lbl_dec == 4'd0);
                end
                PH_KEY: begin
                    n_key    = {r_key[23:0], i_rx_byte};
                    n_lbl    = lbl_dec;
                    do_begin = (lbl_dec == 4'd0);
                end
                PH_PAYLOAD: begin
                    n_kidx = r_kidx + 2'd1;
                    n_fr   = fr_dec;
                    if (last) begin
                        n_phase = PH_HDR1;
                    end
                    if (is_data) begin
                        evt_valid         = 1'b1;
                        evt.event_kind    = EV_BYTE;
                        evt.payload_byte  = r_masked ? (i_rx_byte ^ key_byte) : i_rx_byte;
                        evt.message_type  = r_mop;
                        evt.message_last  = last && r_final;
                        if (last && r_final) begin
                            n_ml  = 32'd0;
                            n_mop = OP_CONT;
                        end
                    end
                end
                default: begin
                    // dead: drop everything until reset
                end
            endcase

            if (do_check) begin
                if (is_data && too_big) begin
                    n_phase        = PH_DEAD;
                    evt_valid      = 1'b1;
                    evt.event_kind = EV_TOO_LARGE;
                end else begin
                    if (is_data) begin
                        n_ml = sum[31:0];
                    end
                    do_after = 1'b1;
                end
            end

            if (do_after) begin
                if (masked_now) begin
                    n_phase = PH_KEY;
                    n_lbl   = 4'd4;
                    n_key   = 32'd0;
                end else begin
                    do_begin = 1'b1;
                end
            end

            if (do_begin) begin
                if (bp_fr != 64'd0) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_HDR1;
                    if (is_data && r_final) begin
                        evt_valid        = 1'b1;
                        evt.event_kind   = EV_EMPTY_END;
                        evt.message_type = r_mop;
                        evt.message_last = 1'b1;
                        n_ml             = 32'd0;
                        n_mop            = OP_CONT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR1;
            r_final  <= 1'b0;
            r_opcode <= OP_CONT;
            r_masked <= 1'b0;
            r_lbl    <= 4'd0;
            r_fr     <= 64'd0;
            r_key    <= 32'd0;
            r_kidx   <= 2'd0;
            r_ml     <= 32'd0;
            r_mop    <= OP_CONT;
        end else begin
            r_phase  <= n_phase;
            r_final  <= n_final;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_lbl    <= n_lbl;
            r_fr     <= n_fr;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
            r_ml     <= n_ml;
            r_mop    <= n_mop;
        end
    end

    assign o_evt              = evt;
    assign o_status.evt_valid = evt_valid;
    assign o_status.dead      = (r_phase >= PH_DEAD);

endmodule

[sv/wsfr_evq.sv]
// Back end: event queue between the parser and the result port.
`timescale 1ns / 1ps

module wsfr_evq import wsfr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_en,
    input  t_event i_wr_data,
    input  logic   i_rd_en,
    output t_event o_rd_data,
    output logic   o_full,
    output logic   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_event        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_wr;
    logic          do_rd;

    always_comb begin
        do_wr    = i_wr_en && !o_full;
        do_rd    = i_rd_en && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({do_wr, do_rd})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);

endmodule

[sv/websocket_frame_receiver.sv]
// Top level of the WebSocket frame receiver: config register, parser and event queue.
`timescale 1ns / 1ps
// WebSocket frame receiver.
// Input side is a queue write port: a received byte is taken on a clock edge
// with push high and full low. One byte per cycle is taken without gaps while full stays low.
// Result side is a queue read port: while empty is low the oldest event sits
// on o_event_kind/o_payload_byte/o_message_type/o_message_last; pop with
// empty low takes that beat.
// Each byte gives zero or one event; an event is visible in the cycle after its
// byte was taken. The parser handles each byte combinationally,
// so throughput is one byte per cycle as long as results are drained.
// Between parser and output sits a QDEPTH-entry event queue; if the receiver
// stops popping, full rises once the queue holds QDEPTH events and the byte
// stream stalls until a beat is popped. No event is dropped.
// Config: i_cfg_data is the maximum message size, written when i_cfg_valid is
// high (o_cfg_ready is always high); write it only while the block is idle.
// Synchronous reset clears the parser to expect a first header byte, empties
// the queue and restores the size limit to 32 MiB. After a close frame or an
// oversized message all further bytes are dropped until reset.

`include "websocket_frame_receiver_defines.svh"

module websocket_frame_receiver import wsfr_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_message_type,
    output logic        o_message_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]   r_max_size;
    logic          w_accept;
    t_event        w_evt;
    t_event        w_out;
    t_front_status w_fstat;
    logic          w_last_kind_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_size <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    wsfr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .i_max_size (r_max_size),
        .o_evt      (w_evt),
        .o_status   (w_fstat)
    );

    wsfr_evq #(
        .DEPTH (QDEPTH)
    ) u_evq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_fstat.evt_valid),
        .i_wr_data (w_evt),
        .i_rd_en   (pop),
        .o_rd_data (w_out),
        .o_full    (full),
        .o_empty   (empty)
    );

    assign o_event_kind   = w_out.event_kind;
    assign o_payload_byte = w_out.payload_byte;
    assign o_message_type = w_out.message_type;
    assign o_message_last = w_out.message_last;

    // only payload bytes and empty message ends may close a message
    assign w_last_kind_ok = !w_evt.message_last || (w_evt.event_kind == EV_BYTE) ||
                            (w_evt.event_kind == EV_EMPTY_END);

    `ASSERT_NEXT(a_dead_sticky, i_clk, i_rst_n, w_fstat.dead, w_fstat.dead)
    `ASSERT_IMPL(a_dead_silent, i_clk, i_rst_n, w_fstat.dead, !w_fstat.evt_valid)
    `ASSERT_NEXT(a_evt_lands, i_clk, i_rst_n, w_fstat.evt_valid, !empty)
    `ASSERT_IMPL(a_last_kind, i_clk, i_rst_n, w_fstat.evt_valid, w_last_kind_ok)

endmodule

[tb/websocket_frame_receiver_tb.sv]
// Self-checking testbench for the WebSocket frame receiver.
`timescale 1ns / 1ps

module websocket_frame_receiver_tb import wsfr_pkg::*; ();

    localparam int         IDLE_LIMIT = 2000;
    localparam logic [3:0] OP_PONG    = 4'hA;
    localparam logic [3:0] OP_RSV_5   = 4'h5;

    typedef enum logic [2:0] {
        PH_HDR1, PH_HDR2, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_DEAD
    } t_parse_phase;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_form;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        empty;
    logic        pop         = 1'b0;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_payload_byte;
    logic [3:0]  o_message_type;
    logic        o_message_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = 32'd0;

    websocket_frame_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_event_kind   (o_event_kind),
        .o_payload_byte (o_payload_byte),
        .o_message_type (o_message_type),
        .o_message_last (o_message_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // deframer shadow state
    t_parse_phase cur_phase  = PH_HDR1;
    logic         frame_fin  = 1'b0;
    logic [3:0]   frame_op   = OP_CONT;
    logic         frame_mask = 1'b0;
    logic [3:0]   len_left   = 4'd0;
    logic [63:0]  remain     = 64'd0;
    logic [31:0]  mask_key   = 32'd0;
    logic [1:0]   key_idx    = 2'd0;
    logic [31:0]  msg_len    = 32'd0;
    logic [3:0]   msg_op     = OP_CONT;
    logic [31:0]  size_limit = MAX_SIZE_RESET;

    t_event due_events[$];

    int     errors        = 0;
    int     bytes_sent    = 0;
    longint open_msg_len  = 0;  // bytes of the message open on the send side
    bit     quiet         = 1'b0;
    int     hold_request  = 0;
    int     hold_left     = 0;
    int     stall_left    = 0;

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void expect_event(input logic [2:0] kind, input logic [7:0] data,
                                         input logic [3:0] mtype, input logic last);
        t_event ev;
        ev.event_kind   = kind;
        ev.payload_byte = data;
        ev.message_type = mtype;
        ev.message_last = last;
        due_events.push_back(ev);
    endfunction

    function automatic bit frame_is_data();
        return frame_op <= OP_BINARY;
    endfunction

    function automatic void close_message();
        msg_len = 32'd0;
        msg_op  = OP_CONT;
    endfunction

    function automatic void enter_payload();
        if (remain != 0) begin
            cur_phase = PH_PAYLOAD;
        end else begin
            cur_phase = PH_HDR1;
            if (frame_is_data() && frame_fin) begin
                expect_event(EV_EMPTY_END, 8'h00, msg_op, 1'b1);
                close_message();
            end
        end
    endfunction

    function automatic void after_length();
        if (frame_mask) begin
            cur_phase = PH_KEY;
            len_left  = 4'd4;
            mask_key  = 32'd0;
        end else begin
            enter_payload();
        end
    endfunction

    function automatic void length_complete();
        logic [63:0] lim;
        lim = {32'd0, size_limit};
        if (frame_is_data() && (remain >= lim || {32'd0, msg_len} + remain >= lim)) begin
            cur_phase = PH_DEAD;
            expect_event(EV_TOO_LARGE, 8'h00, OP_CONT, 1'b0);
        end else begin
            if (frame_is_data()) msg_len = msg_len + remain[31:0];
            after_length();
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [6:0] code;
        logic [7:0] k;
        case (cur_phase)
            PH_HDR1: begin
                frame_fin = b[7];
                frame_op  = b[3:0];
                if ((frame_op == OP_TEXT || frame_op == OP_BINARY) && msg_op == OP_CONT)
                    msg_op = frame_op;
                key_idx   = 2'd0;
                cur_phase = PH_HDR2;
            end
            PH_HDR2: begin
                code       = b[6:0];
                frame_mask = b[7];
                remain     = 64'd0;
                if (frame_op == OP_CLOSE) begin
                    cur_phase = PH_DEAD;
                    expect_event(EV_CLOSED, 8'h00, OP_CONT, 1'b0);
                end else begin
                    if (code == LEN16_CODE || code == LEN64_CODE) begin
                        len_left  = (code == LEN16_CODE) ? 4'd2 : 4'd8;
                        cur_phase = PH_EXTLEN;
                    end
                    if (frame_op == OP_PING) begin
                        // pong goes out now, the rest of the ping is skipped
                        if (cur_phase != PH_EXTLEN) begin
                            remain = {57'd0, code};
                            after_length();
                        end
                        expect_event(EV_PONG, 8'h00, OP_CONT, 1'b0);
                    end else if (cur_phase != PH_EXTLEN) begin
                        remain = {57'd0, code};
                        length_complete();
                    end
                end
            end
            PH_EXTLEN: begin
                remain   = {remain[55:0], b};
                len_left = len_left - 4'd1;
                if (len_left == 0) length_complete();
            end
            PH_KEY: begin
                mask_key = {mask_key[23:0], b};
                len_left = len_left - 4'd1;
                if (len_left == 0) enter_payload();
            end
            PH_PAYLOAD: begin
                k       = frame_mask ? mask_key[8 * (3 - key_idx) +: 8] : 8'h00;
                key_idx = key_idx + 2'd1;
                remain  = remain - 64'd1;
                if (remain == 0) cur_phase = PH_HDR1;
                if (frame_is_data()) begin
                    expect_event(EV_BYTE, b ^ k, msg_op, remain == 0 && frame_fin);
                    if (remain == 0 && frame_fin) close_message();
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one byte; push stays high on return so back-to-back beats need no gap.
    task automatic push_byte(input logic [7:0] data);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= data;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        deframe_byte(data);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input int unsigned n, input t_len_form form);
        logic [2:0]  rsv;
        logic [6:0]  code;
        logic [63:0] ext;
        logic [31:0] key_bytes;
        logic [7:0]  data;
        int          ext_bytes;
        rsv       = 3'($urandom);
        key_bytes = $urandom;
        ext       = {32'd0, n};
        case (form)
            LEN_SHORT: begin
                code      = n[6:0];
                ext_bytes = 0;
            end
            LEN_EXT16: begin
                code      = LEN16_CODE;
                ext_bytes = 2;
            end
            default: begin
                code      = LEN64_CODE;
                ext_bytes = 8;
            end
        endcase
        push_byte({fin, rsv, op});
        push_byte({masked, code});
        for (int i = ext_bytes - 1; i >= 0; i--) push_byte(ext[8 * i +: 8]);
        if (masked)
            for (int i = 3; i >= 0; i--) push_byte(key_bytes[8 * i +: 8]);
        for (int unsigned i = 0; i < n; i++) begin
            data = 8'($urandom);
            push_byte(data);
        end
        if (op <= OP_BINARY) begin
            if (fin) open_msg_len = 0;
            else     open_msg_len = open_msg_len + n;
        end
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned u;
        int unsigned n;
        longint      budget;
        t_len_form   form;
        logic [3:0]  op;
        logic        fin;
        logic        masked;
        pick = $urandom_range(0, 99);
        if (pick < 28)      op = OP_CONT;
        else if (pick < 49) op = OP_TEXT;
        else if (pick < 70) op = OP_BINARY;
        else if (pick < 80) op = OP_PING;
        else if (pick < 88) op = OP_PONG;
        else begin
            // reserved opcodes only
            do begin
                u  = $urandom_range(3, 15);
                op = u[3:0];
            end while (op == OP_CLOSE || op == OP_PING || op == OP_PONG);
        end
        u = $urandom_range(0, 9);
        form = (u < 7) ? LEN_SHORT : (u < 9) ? LEN_EXT16 : LEN_EXT64;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, (form == LEN_EXT16) ? 300 : 125);
        else
            n = $urandom_range(0, 12);
        if (op <= OP_BINARY) begin
            // keep the message under the limit until the very end
            budget = longint'(size_limit);
            budget = budget - 1 - open_msg_len;
            if (longint'(n) > budget) n = 32'(budget);
            fin = ($urandom_range(0, 2) != 0);
        end else begin
            fin = 1'($urandom_range(0, 1));
        end
        masked = 1'($urandom_range(0, 1));
        send_frame(fin, op, masked, n, form);
    endtask

    task automatic send_random_until(input int target);
        while (bytes_sent < target) send_random_frame();
    endtask

    task automatic wait_drained(input int tail);
        while (due_events.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_size_limit(input logic [31:0] limit);
        send_frame(1'b1, OP_CONT, 1'b0, 0, LEN_SHORT);  // end any open message
        push <= 1'b0;
        wait_drained(4);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        size_limit = limit;
    endtask

    task automatic test_directed_frames();
        send_frame(1'b1, OP_TEXT, 1'b1, 2, LEN_SHORT);
        send_frame(1'b0, OP_CONT, 1'b0, 1, LEN_SHORT);   // untyped leading continuation
        send_frame(1'b1, OP_BINARY, 1'b0, 0, LEN_SHORT); // empty final frame ends it
        send_frame(1'b1, OP_PING, 1'b0, 0, LEN_SHORT);
        send_frame(1'b1, OP_TEXT, 1'b0, 1, LEN_EXT16);
        send_frame(1'b1, OP_RSV_5, 1'b1, 1, LEN_SHORT);  // payload skipped
    endtask

    task automatic test_limit_extremes();
        write_size_limit(32'hFFFF_FFFF);
        send_random_until(bytes_sent + 300);
        write_size_limit(32'd1);  // only empty data frames fit
        send_random_until(bytes_sent + 150);
    endtask

    task automatic test_random_limits();
        logic [31:0] limit;
        write_size_limit($urandom_range(20, 400));
        send_random_until(bytes_sent + 400);
        limit = $urandom;
        if (limit == 0) limit = 32'd1;
        write_size_limit(limit);
        send_random_until(bytes_sent + 400);
    endtask

    task automatic test_backpressure();
        hold_request = 120;
        send_random_until(bytes_sent + 150);
    endtask

    task automatic test_quiet_stream();
        quiet = 1'b1;
        send_random_until(bytes_sent + 300);
    endtask

    // Ends reception by a close or an oversized frame, then feeds bytes that must be dropped.
    task automatic test_end_of_stream();
        logic [7:0] data;
        data = 8'($urandom);
        if ($urandom_range(0, 1)) begin
            push_byte({1'b1, 3'b000, OP_CLOSE});
            push_byte(data);
        end else begin
            push_byte({1'b1, 3'b000, OP_TEXT});
            push_byte({data[7], LEN64_CODE});
            push_byte(data | 8'h80);  // bit 63 set
            repeat (7) begin
                data = 8'($urandom);
                push_byte(data);
            end
        end
        repeat (20) begin
            data = 8'($urandom);
            push_byte(data);
        end
    endtask

    // result side: checks each popped beat and paces pop
    always @(posedge i_clk) begin
        t_event want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (due_events.size() == 0) begin
                    flag_error($sformatf("unexpected event kind %0d byte %02h type %0d last %0d",
                                         o_event_kind, o_payload_byte, o_message_type,
                                         o_message_last));
                end else begin
                    want = due_events.pop_front();
                    if (o_event_kind !== want.event_kind)
                        flag_error($sformatf("event_kind: expected %0d, got %0d",
                                             want.event_kind, o_event_kind));
                    if (o_payload_byte !== want.payload_byte)
                        flag_error($sformatf("payload_byte: expected %02h, got %02h",
                                             want.payload_byte, o_payload_byte));
                    if (o_message_type !== want.message_type)
                        flag_error($sformatf("message_type: expected %0d, got %0d",
                                             want.message_type, o_message_type));
                    if (o_message_last !== want.message_last)
                        flag_error($sformatf("message_last: expected %0d, got %0d",
                                             want.message_last, o_message_last));
                end
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 10);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_limit_extremes();
        test_random_limits();
        test_backpressure();
        test_quiet_stream();
        test_end_of_stream();
        push <= 1'b0;
        wait_drained(10);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
